@@ design/hsc_pkg.sv @@
// hsc_pkg: types, constants and merge tables for the three-set hangul composer
// no dependencies; used by hangul_three_set_syllable_composer_unit
package hsc_pkg;

    // composition phase, one-hot
    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_INIT  = 7'b0000010,
        PH_DINIT = 7'b0000100,
        PH_MED   = 7'b0001000,
        PH_CMED  = 7'b0010000,
        PH_FIN   = 7'b0100000,
        PH_CFIN  = 7'b1000000
    } t_phase;

    // jamo kind from key bits 6:5
    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_MED  = 2'd1,
        KIND_FIN  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // phase numbers as seen on the result port
    localparam logic [2:0] PC_START = 3'd0;
    localparam logic [2:0] PC_INIT  = 3'd1;
    localparam logic [2:0] PC_DINIT = 3'd2;
    localparam logic [2:0] PC_MED   = 3'd3;
    localparam logic [2:0] PC_CMED  = 3'd4;
    localparam logic [2:0] PC_FIN   = 3'd5;
    localparam logic [2:0] PC_CFIN  = 3'd6;

    localparam logic [15:0] FILL_CODE = 16'h8441;
    localparam logic [7:0]  NO_MERGE  = 8'h00;

    function automatic logic [2:0] f_phase_code(input t_phase ph);
        logic [2:0] pc;
        unique case (ph)
            PH_START: pc = PC_START;
            PH_INIT:  pc = PC_INIT;
            PH_DINIT: pc = PC_DINIT;
            PH_MED:   pc = PC_MED;
            PH_CMED:  pc = PC_CMED;
            PH_FIN:   pc = PC_FIN;
            PH_CFIN:  pc = PC_CFIN;
            default:  pc = PC_START;
        endcase
        return pc;
    endfunction

    // phase entered when a syllable opens with a key of this kind
    function automatic t_phase f_first_phase(input t_kind kind);
        t_phase ph;
        unique case (kind)
            KIND_INIT: ph = PH_INIT;
            KIND_MED:  ph = PH_MED;
            default:   ph = PH_FIN;
        endcase
        return ph;
    endfunction

    // doubled initials
    function automatic logic [7:0] f_init_merge(input logic [7:0] prev, input logic [7:0] key);
        logic [7:0] m;
        unique case ({prev, key})
            16'h8282: m = 8'h83;
            16'h8585: m = 8'h86;
            16'h8989: m = 8'h8a;
            16'h8b8b: m = 8'h8c;
            16'h8e8e: m = 8'h8f;
            default:  m = NO_MERGE;
        endcase
        return m;
    endfunction

    // compound medials
    function automatic logic [7:0] f_med_merge(input logic [7:0] prev, input logic [7:0] key);
        logic [7:0] m;
        unique case ({prev, key})
            16'hada3: m = 8'hae;
            16'hada4: m = 8'haf;
            16'hadbd: m = 8'hb2;
            16'hb4a7: m = 8'hb5;
            16'hb4aa: m = 8'hb6;
            16'hb4bd: m = 8'hb7;
            16'hbbbd: m = 8'hbc;
            default:  m = NO_MERGE;
        endcase
        return m;
    endfunction

    // compound finals
    function automatic logic [7:0] f_fin_merge(input logic [7:0] prev, input logic [7:0] key);
        logic [7:0] m;
        unique case ({prev, key})
            16'hc2c2: m = 8'hc3;
            16'hc2d5: m = 8'hc4;
            16'hc5d8: m = 8'hc6;
            16'hc5dd: m = 8'hc7;
            16'hc9c2: m = 8'hca;
            16'hc9d1: m = 8'hcb;
            16'hc9d3: m = 8'hcc;
            16'hc9d5: m = 8'hcd;
            16'hc9db: m = 8'hce;
            16'hc9dc: m = 8'hcf;
            16'hc9dd: m = 8'hd0;
            16'hd3d5: m = 8'hd4;
            16'hd5d5: m = 8'hd6;
            default:  m = NO_MERGE;
        endcase
        return m;
    endfunction

endpackage

@@ design/hangul_three_set_syllable_composer_unit.sv @@
// three-set hangul syllable composer: jamo keys in, johab syllable codes out
// depends on hsc_pkg (phase type, merge tables, fill code)
// path from key accepted to result valid: input register, then result register
// throughput: one key per cycle while the result side does not stall the input register
// reset (synchronous, active low): phase start, code 0x8441, previous key 0, both stages empty
// results wait in the result register; the input register keeps taking keys until it is full
module hangul_three_set_syllable_composer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // key channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_code,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_syllable_done,
    output logic [15:0] o_finished_code,
    output logic [15:0] o_current_code,
    output logic [2:0]  o_current_phase
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_key;

    // composition state
    hsc_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_code,  n_code;
    logic [7:0]      r_prev_key;

    // result register
    logic        r_out_valid;
    logic        r_done,     n_done;
    logic [15:0] r_finished, n_finished;
    logic [15:0] r_cur_code;
    logic [2:0]  r_cur_phase;

    // handshake: result register loads when empty or being taken
    logic out_load;
    logic advance;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    // composition step for the key in the input register
    hsc_pkg::t_kind kind;
    logic [7:0]     m_init, m_med, m_fin;
    logic [7:0]     val;
    logic [15:0]    base;
    logic           close;

    assign kind   = hsc_pkg::t_kind'(r_in_key[6:5]);
    assign m_init = hsc_pkg::f_init_merge(r_prev_key, r_in_key);
    assign m_med  = hsc_pkg::f_med_merge(r_prev_key, r_in_key);
    assign m_fin  = hsc_pkg::f_fin_merge(r_prev_key, r_in_key);

    always_comb begin
        n_phase    = r_phase;
        n_code     = r_code;
        n_done     = 1'b0;
        n_finished = 16'h0000;
        val        = r_in_key;
        close      = 1'b0;
        base       = (r_phase == hsc_pkg::PH_START) ? hsc_pkg::FILL_CODE : r_code;

        if (kind != hsc_pkg::KIND_NONE) begin
            unique case (r_phase)
                hsc_pkg::PH_INIT: begin
                    if (kind == hsc_pkg::KIND_INIT) begin
                        if (m_init != hsc_pkg::NO_MERGE) begin
                            val     = m_init;
                            n_phase = hsc_pkg::PH_DINIT;
                        end else begin
                            close = 1'b1;
                        end
                    end else begin
                        n_phase = hsc_pkg::f_first_phase(kind);
                    end
                end
                hsc_pkg::PH_DINIT: begin
                    if (kind == hsc_pkg::KIND_INIT) begin
                        close = 1'b1;
                    end else begin
                        n_phase = hsc_pkg::f_first_phase(kind);
                    end
                end
                hsc_pkg::PH_MED: begin
                    if (kind == hsc_pkg::KIND_INIT) begin
                        close = 1'b1;
                    end else if (kind == hsc_pkg::KIND_MED) begin
                        if (m_med != hsc_pkg::NO_MERGE) begin
                            val     = m_med;
                            n_phase = hsc_pkg::PH_CMED;
                        end else begin
                            close = 1'b1;
                        end
                    end else begin
                        n_phase = hsc_pkg::PH_FIN;
                    end
                end
                hsc_pkg::PH_CMED: begin
                    if (kind == hsc_pkg::KIND_FIN) begin
                        n_phase = hsc_pkg::PH_FIN;
                    end else begin
                        close = 1'b1;
                    end
                end
                hsc_pkg::PH_FIN: begin
                    if (kind == hsc_pkg::KIND_FIN && m_fin != hsc_pkg::NO_MERGE) begin
                        val     = m_fin;
                        n_phase = hsc_pkg::PH_CFIN;
                    end else begin
                        close = 1'b1;
                    end
                end
                hsc_pkg::PH_CFIN: begin
                    close = 1'b1;
                end
                default: begin
                    // start phase, and any code that cannot arise
                    n_phase = hsc_pkg::f_first_phase(kind);
                end
            endcase

            // key does not fit: hand out the syllable and open a new one with it
            if (close) begin
                n_done     = 1'b1;
                n_finished = base;
                base       = hsc_pkg::FILL_CODE;
                val        = r_in_key;
                n_phase    = hsc_pkg::f_first_phase(kind);
            end

            // drop the jamo into its field of the johab code
            unique case (kind)
                hsc_pkg::KIND_INIT: n_code = {base[15], val[4:0], base[9:0]};
                hsc_pkg::KIND_MED:  n_code = {base[15:10], val[4:0], base[4:0]};
                default:            n_code = {base[15:5], val[4:0]};
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_key <= i_key_code;
        end
    end

    // composition state, updated once per accepted jamo key; keys of kind none leave it unchanged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hsc_pkg::PH_START;
            r_code     <= hsc_pkg::FILL_CODE;
            r_prev_key <= 8'h00;
        end else if (advance && kind != hsc_pkg::KIND_NONE) begin
            r_phase    <= n_phase;
            r_code     <= n_code;
            r_prev_key <= r_in_key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_done      <= n_done;
            r_finished  <= n_finished;
            r_cur_code  <= n_code;
            r_cur_phase <= hsc_pkg::f_phase_code(n_phase);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_syllable_done = r_done;
    assign o_finished_code = r_finished;
    assign o_current_code  = r_cur_code;
    assign o_current_phase = r_cur_phase;

    // a held key in the input register stays put until the result side frees up
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_load |=> r_in_valid && $stable(r_in_key))
        else $error("input register lost a stalled key");

    // a closed syllable always carries the johab marker bit
    a_done_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_finished[15])
        else $error("finished code without johab marker bit");

    // no finished code unless a syllable closed
    a_no_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_done |-> r_finished == 16'h0000)
        else $error("finished code set without close");

    // a new syllable only ever opens in a single-jamo phase
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |->
            (r_cur_phase == hsc_pkg::PC_INIT || r_cur_phase == hsc_pkg::PC_MED ||
             r_cur_phase == hsc_pkg::PC_FIN))
        else $error("syllable closed into a compound phase");

    // state register holds a single phase, and its code keeps the johab marker bit
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase) && r_code[15])
        else $error("composition state corrupt");

endmodule
